[hw/rtl/snl_pkg.sv]
`timescale 1ns / 1ps

package snl_pkg;

   // Fixed internal formats: angles Q.20 degrees, sines Q2.30
   localparam int DEG_SHIFT = 20;
   localparam int ATAN_W    = 28;
   localparam int ANGLE_W   = 17;
   localparam int INDEX_W   = 16;
   localparam int SINE_W    = 32;
   localparam int MAG_W     = 31;
   localparam int CORDIC_W  = 34;
   localparam int NUM_W     = 47;
   localparam int QUOT_W    = 32;
   localparam int ANSWER_W  = 17;

   localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;
   localparam logic [MAG_W-1:0]           UNIT_Q30    = 31'h4000_0000;
   localparam logic [INDEX_W-1:0]         INDEX_MAX   = 16'hFFFF;

   typedef enum logic [1:0] {
      MODE_INDEX_ONE  = 2'd0,
      MODE_INDEX_TWO  = 2'd1,
      MODE_INCIDENCE  = 2'd2,
      MODE_REFRACTION = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_ASIN     = 2'd1,
      STATUS_ZERO_DIV = 2'd2,
      STATUS_SAT      = 2'd3
   } status_type;

   // Operands that ride along with the sine pipeline
   typedef struct packed {
      mode_type              mode;
      logic [INDEX_W-1:0]    index_one;
      logic [INDEX_W-1:0]    index_two;
   } item_tag_type;

   // Flags that ride along with the divider
   typedef struct packed {
      logic angle_mode;
      logic zero_div;
      logic neg;
   } div_tag_type;

   // atan(2^-k) in degrees, Q.20
   function automatic logic signed [ATAN_W-1:0] atan_deg(input int unsigned k);
      logic signed [ATAN_W-1:0] v;
      case (k)
         0:       v = 28'sd47185920;
         1:       v = 28'sd27855475;
         2:       v = 28'sd14718068;
         3:       v = 28'sd7471121;
         4:       v = 28'sd3750058;
         5:       v = 28'sd1876857;
         6:       v = 28'sd938658;
         7:       v = 28'sd469357;
         8:       v = 28'sd234682;
         9:       v = 28'sd117342;
         10:      v = 28'sd58671;
         11:      v = 28'sd29335;
         12:      v = 28'sd14668;
         13:      v = 28'sd7334;
         14:      v = 28'sd3667;
         15:      v = 28'sd1833;
         16:      v = 28'sd917;
         17:      v = 28'sd458;
         18:      v = 28'sd229;
         19:      v = 28'sd115;
         20:      v = 28'sd57;
         21:      v = 28'sd29;
         22:      v = 28'sd14;
         23:      v = 28'sd7;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

[hw/rtl/snl_req_if.sv]
`timescale 1ns / 1ps

interface snl_req_if;
   logic                valid;
   logic                ready;
   logic [1:0]          mode;
   logic [15:0]         index_one;
   logic [15:0]         index_two;
   logic signed [16:0]  incidence_deg;
   logic signed [16:0]  refraction_deg;

   modport source (output valid, mode, index_one, index_two, incidence_deg,
                   refraction_deg, input ready);
   modport sink   (input valid, mode, index_one, index_two, incidence_deg,
                   refraction_deg, output ready);
endinterface

[hw/rtl/snl_rsp_if.sv]
`timescale 1ns / 1ps

interface snl_rsp_if;
   logic                valid;
   logic                ready;
   logic signed [16:0]  answer;
   logic [1:0]          status;

   modport source (output valid, answer, status, input ready);
   modport sink   (input valid, answer, status, output ready);
endinterface

[hw/rtl/snl_sine_cordic.sv]
`timescale 1ns / 1ps

module snl_sine_cordic
   import snl_pkg::*;
#(
   parameter int ANGLE_FRAC_BITS = 8,
   parameter int TRIG_ITERATIONS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     advance,
   input  logic                     in_valid,
   input  logic [1:0][ANGLE_W-1:0]  in_angle,
   input  item_tag_type             in_tag,
   output logic                     out_valid,
   output logic [1:0][SINE_W-1:0]   out_sine,
   output item_tag_type             out_tag
);

   localparam int SCALE_SH = DEG_SHIFT - ANGLE_FRAC_BITS;
   localparam int RAW_W    = ANGLE_W + SCALE_SH;
   localparam int AW       = ((RAW_W > 30) ? RAW_W : 30) + 2;
   localparam int ZW       = AW + 1;
   localparam int LAST     = TRIG_ITERATIONS + 2;
   localparam longint DEG_90_L = 90 * (longint'(1) << DEG_SHIFT);
   localparam logic signed [AW-1:0] DEG_90  = AW'(DEG_90_L);
   localparam logic signed [AW-1:0] DEG_180 = AW'(2 * DEG_90_L);
   localparam logic signed [AW-1:0] DEG_360 = AW'(4 * DEG_90_L);
   localparam logic signed [CORDIC_W-1:0] Y_ONE     = CORDIC_W'(UNIT_Q30);
   localparam logic signed [CORDIC_W-1:0] Y_NEG_ONE = -Y_ONE;

   logic                        vld_ff [0:LAST];
   item_tag_type                tag_ff [0:LAST];
   logic signed [AW-1:0]        wrap_ff [2];
   logic signed [CORDIC_W-1:0]  x_ff [2][TRIG_ITERATIONS+1];
   logic signed [CORDIC_W-1:0]  y_ff [2][TRIG_ITERATIONS+1];
   logic signed [ZW-1:0]        z_ff [2][TRIG_ITERATIONS+1];
   logic                        zero_ff [2][TRIG_ITERATIONS+1];
   logic signed [SINE_W-1:0]    sine_ff [2];

   // Valid bits travel with the words
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= LAST; j++) vld_ff[j] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= in_valid;
         for (int j = 1; j <= LAST; j++) vld_ff[j] <= vld_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         tag_ff[0] <= in_tag;
         for (int j = 1; j <= LAST; j++) tag_ff[j] <= tag_ff[j-1];
      end
   end

   for (genvar l = 0; l < 2; l++) begin : g_lane
      logic signed [AW-1:0] raw;
      logic signed [AW-1:0] wrap_in;
      logic signed [AW-1:0] fold_in;

      // Scale to Q.20 and wrap once into (-180, 180]
      always_comb begin
         raw = AW'($signed(in_angle[l])) <<< SCALE_SH;
         if (raw > DEG_180) begin
            wrap_in = raw - DEG_360;
         end else if (raw <= -DEG_180) begin
            wrap_in = raw + DEG_360;
         end else begin
            wrap_in = raw;
         end
      end

      // Fold into [-90, 90]: sin(180 - a) = sin(a)
      always_comb begin
         if (wrap_ff[l] > DEG_90) begin
            fold_in = DEG_180 - wrap_ff[l];
         end else if (wrap_ff[l] < -DEG_90) begin
            fold_in = -DEG_180 - wrap_ff[l];
         end else begin
            fold_in = wrap_ff[l];
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            wrap_ff[l]    <= wrap_in;
            x_ff[l][0]    <= CORDIC_GAIN;
            y_ff[l][0]    <= '0;
            z_ff[l][0]    <= ZW'(fold_in);
            zero_ff[l][0] <= (fold_in == '0);
         end
      end

      // One rotation step per stage
      for (genvar k = 0; k < TRIG_ITERATIONS; k++) begin : g_iter
         localparam logic signed [ZW-1:0] ATAN_K = ZW'(atan_deg(k));
         logic signed [CORDIC_W-1:0] dx;
         logic signed [CORDIC_W-1:0] dy;

         assign dx = y_ff[l][k] >>> k;
         assign dy = x_ff[l][k] >>> k;

         always_ff @(posedge clock) begin
            if (advance) begin
               zero_ff[l][k+1] <= zero_ff[l][k];
               if (!z_ff[l][k][ZW-1]) begin
                  x_ff[l][k+1] <= x_ff[l][k] - dx;
                  y_ff[l][k+1] <= y_ff[l][k] + dy;
                  z_ff[l][k+1] <= z_ff[l][k] - ATAN_K;
               end else begin
                  x_ff[l][k+1] <= x_ff[l][k] + dx;
                  y_ff[l][k+1] <= y_ff[l][k] - dy;
                  z_ff[l][k+1] <= z_ff[l][k] + ATAN_K;
               end
            end
         end
      end

      // Clamp to [-1, 1]; an exact zero angle gives zero
      always_ff @(posedge clock) begin
         if (advance) begin
            if (zero_ff[l][TRIG_ITERATIONS]) begin
               sine_ff[l] <= '0;
            end else if (y_ff[l][TRIG_ITERATIONS] > Y_ONE) begin
               sine_ff[l] <= SINE_W'(Y_ONE);
            end else if (y_ff[l][TRIG_ITERATIONS] < Y_NEG_ONE) begin
               sine_ff[l] <= SINE_W'(Y_NEG_ONE);
            end else begin
               sine_ff[l] <= SINE_W'(y_ff[l][TRIG_ITERATIONS]);
            end
         end
      end

      assign out_sine[l] = sine_ff[l];
   end

   assign out_valid = vld_ff[LAST];
   assign out_tag   = tag_ff[LAST];

endmodule

[hw/rtl/snl_divider.sv]
`timescale 1ns / 1ps

module snl_divider
   import snl_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               advance,
   input  logic               in_valid,
   input  logic [NUM_W-1:0]   in_num,
   input  logic [MAG_W-1:0]   in_den,
   input  div_tag_type        in_tag,
   output logic               out_valid,
   output logic [QUOT_W-1:0]  out_quot,
   output logic               out_ovf,
   output div_tag_type        out_tag
);

   logic                vld_ff  [0:QUOT_W];
   div_tag_type         tag_ff  [0:QUOT_W];
   logic [MAG_W-1:0]    den_ff  [0:QUOT_W];
   logic [MAG_W-1:0]    rem_ff  [0:QUOT_W];
   logic [QUOT_W-1:0]   word_ff [0:QUOT_W];
   logic                ovf_ff  [0:QUOT_W];
   logic [NUM_W-1:0]    biased_in;
   logic [MAG_W-1:0]    high_in;

   // Round to nearest: add half the divisor up front
   assign biased_in = in_num + NUM_W'(in_den >> 1);
   assign high_in   = MAG_W'(biased_in[NUM_W-1:QUOT_W]);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= QUOT_W; j++) vld_ff[j] <= 1'b0;
      end else if (advance) begin
         vld_ff[0] <= in_valid;
         for (int j = 1; j <= QUOT_W; j++) vld_ff[j] <= vld_ff[j-1];
      end
   end

   // Quotient too wide when the high part already holds the divisor
   always_ff @(posedge clock) begin
      if (advance) begin
         tag_ff[0]  <= in_tag;
         den_ff[0]  <= in_den;
         rem_ff[0]  <= high_in;
         word_ff[0] <= biased_in[QUOT_W-1:0];
         ovf_ff[0]  <= (high_in >= in_den);
      end
   end

   // Restoring division, one quotient bit per stage
   for (genvar i = 0; i < QUOT_W; i++) begin : g_step
      logic [MAG_W:0] trial;
      logic           fits;

      assign trial = {rem_ff[i], word_ff[i][QUOT_W-1]};
      assign fits  = (trial >= {1'b0, den_ff[i]});

      always_ff @(posedge clock) begin
         if (advance) begin
            tag_ff[i+1]  <= tag_ff[i];
            den_ff[i+1]  <= den_ff[i];
            ovf_ff[i+1]  <= ovf_ff[i];
            word_ff[i+1] <= {word_ff[i][QUOT_W-2:0], fits};
            rem_ff[i+1]  <= fits ? MAG_W'(trial - {1'b0, den_ff[i]}) : MAG_W'(trial);
         end
      end
   end

   assign out_valid = vld_ff[QUOT_W];
   assign out_quot  = word_ff[QUOT_W];
   assign out_ovf   = ovf_ff[QUOT_W];
   assign out_tag   = tag_ff[QUOT_W];

endmodule

[hw/rtl/snell_law_solver.sv]
`timescale 1ns / 1ps

// Channel   Dir  Word
// req_ch    in   mode, index_one, index_two, incidence_deg, refraction_deg
// rsp_ch    out  answer, status
//
// One word enters per cycle while no result is stalled; each passes through two CORDIC
// pipelines, a 32-stage divider and a 31-stage square root on its way to rsp_ch.
// Synchronous active-high reset clears all valid bits; no clearing pass.
// A stalled result freezes every stage; req_ch.ready drops in the same cycle.
module snell_law_solver
   import snl_pkg::*;
#(
   parameter int ANGLE_FRAC_BITS = 8,
   parameter int TRIG_ITERATIONS = 16
) (
   input  logic        clock,
   input  logic        reset,
   snl_req_if.sink     req_ch,
   snl_rsp_if.source   rsp_ch
);

   localparam int SCALE_SH  = DEG_SHIFT - ANGLE_FRAC_BITS;
   localparam int ROOT_W    = MAG_W;
   localparam int RAD_W     = 2 * ROOT_W;
   localparam int SQ_REM_W  = ROOT_W + 2;
   localparam int ZA_W      = ATAN_W + 1;
   localparam logic [RAD_W-1:0]       RAD_ONE    = RAD_W'(1) << (2 * (MAG_W - 1));
   localparam logic signed [ZA_W-1:0] ROUND_HALF = ZA_W'(longint'(1) << (SCALE_SH - 1));

   typedef struct packed {
      logic                  asin_go;
      status_type            status;
      logic [ANSWER_W-1:0]   answer;
   } fin_tag_type;

   function automatic logic [MAG_W-1:0] abs_sine(input logic signed [SINE_W-1:0] s);
      logic signed [SINE_W-1:0] a;
      a = s[SINE_W-1] ? -s : s;
      return a[MAG_W-1:0];
   endfunction

   logic                  advance;
   logic                  rsp_valid_ff;
   logic [ANSWER_W-1:0]   answer_ff;
   status_type            status_ff;

   // Whole pipeline moves unless a result waits in the output register
   assign advance      = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = advance;

   // ---------------- sines of both angles ----------------
   logic [1:0][ANGLE_W-1:0] angle_pair;
   item_tag_type            in_tag;
   logic                    sine_valid;
   logic [1:0][SINE_W-1:0]  sine_pair;
   item_tag_type            sine_tag;

   assign angle_pair[0]    = req_ch.incidence_deg;
   assign angle_pair[1]    = req_ch.refraction_deg;
   assign in_tag.mode      = mode_type'(req_ch.mode);
   assign in_tag.index_one = req_ch.index_one;
   assign in_tag.index_two = req_ch.index_two;

   snl_sine_cordic #(
      .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
      .TRIG_ITERATIONS (TRIG_ITERATIONS)
   ) u_sine (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_ch.valid),
      .in_angle  (angle_pair),
      .in_tag    (in_tag),
      .out_valid (sine_valid),
      .out_sine  (sine_pair),
      .out_tag   (sine_tag)
   );

   // ---------------- operand selection ----------------
   logic signed [SINE_W-1:0] s_inc;
   logic signed [SINE_W-1:0] s_ref;
   logic [INDEX_W-1:0]       op_a_in;
   logic [MAG_W-1:0]         op_b_in;
   logic [MAG_W-1:0]         op_den_in;
   div_tag_type              op_tag_in;

   assign s_inc = $signed(sine_pair[0]);
   assign s_ref = $signed(sine_pair[1]);

   always_comb begin
      op_a_in   = sine_tag.index_two;
      op_b_in   = abs_sine(s_ref);
      op_den_in = abs_sine(s_inc);
      op_tag_in = '0;
      case (sine_tag.mode)
         MODE_INDEX_ONE: begin
            op_a_in            = sine_tag.index_two;
            op_b_in            = abs_sine(s_ref);
            op_den_in          = abs_sine(s_inc);
            op_tag_in.zero_div = (s_inc == '0);
            op_tag_in.neg      = s_ref[SINE_W-1] ^ s_inc[SINE_W-1];
         end
         MODE_INDEX_TWO: begin
            op_a_in            = sine_tag.index_one;
            op_b_in            = abs_sine(s_inc);
            op_den_in          = abs_sine(s_ref);
            op_tag_in.zero_div = (s_ref == '0);
            op_tag_in.neg      = s_inc[SINE_W-1] ^ s_ref[SINE_W-1];
         end
         MODE_INCIDENCE: begin
            op_a_in              = sine_tag.index_two;
            op_b_in              = abs_sine(s_ref);
            op_den_in            = MAG_W'(sine_tag.index_one);
            op_tag_in.angle_mode = 1'b1;
            op_tag_in.zero_div   = (sine_tag.index_one == '0);
            op_tag_in.neg        = s_ref[SINE_W-1];
         end
         MODE_REFRACTION: begin
            op_a_in              = sine_tag.index_one;
            op_b_in              = abs_sine(s_inc);
            op_den_in            = MAG_W'(sine_tag.index_two);
            op_tag_in.angle_mode = 1'b1;
            op_tag_in.zero_div   = (sine_tag.index_two == '0);
            op_tag_in.neg        = s_inc[SINE_W-1];
         end
         default: ;
      endcase
   end

   logic                op_vld_ff;
   logic [INDEX_W-1:0]  op_a_ff;
   logic [MAG_W-1:0]    op_b_ff;
   logic [MAG_W-1:0]    op_den_ff;
   div_tag_type         op_tag_ff;
   logic                prod_vld_ff;
   logic [NUM_W-1:0]    prod_ff;
   logic [MAG_W-1:0]    prod_den_ff;
   div_tag_type         prod_tag_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         op_vld_ff   <= 1'b0;
         prod_vld_ff <= 1'b0;
      end else if (advance) begin
         op_vld_ff   <= sine_valid;
         prod_vld_ff <= op_vld_ff;
      end
   end

   // Operand register, then the product register
   always_ff @(posedge clock) begin
      if (advance) begin
         op_a_ff     <= op_a_in;
         op_b_ff     <= op_b_in;
         op_den_ff   <= op_den_in;
         op_tag_ff   <= op_tag_in;
         prod_ff     <= NUM_W'(op_a_ff * op_b_ff);
         prod_den_ff <= op_den_ff;
         prod_tag_ff <= op_tag_ff;
      end
   end

   // ---------------- rounded quotient ----------------
   logic               div_valid;
   logic [QUOT_W-1:0]  div_quot;
   logic               div_ovf;
   div_tag_type        div_tag;

   snl_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (prod_vld_ff),
      .in_num    (prod_ff),
      .in_den    (prod_den_ff),
      .in_tag    (prod_tag_ff),
      .out_valid (div_valid),
      .out_quot  (div_quot),
      .out_ovf   (div_ovf),
      .out_tag   (div_tag)
   );

   // ---------------- index result or arcsine argument ----------------
   fin_tag_type fin_in;

   always_comb begin
      fin_in = '0;
      fin_in.status = STATUS_OK;
      if (div_tag.zero_div) begin
         fin_in.status = STATUS_ZERO_DIV;
      end else if (!div_tag.angle_mode) begin
         if (div_tag.neg && (div_ovf || div_quot != '0)) begin
            fin_in.status = STATUS_SAT;
         end else if (div_ovf || div_quot > QUOT_W'(INDEX_MAX)) begin
            fin_in.status = STATUS_SAT;
            fin_in.answer = ANSWER_W'(INDEX_MAX);
         end else begin
            fin_in.answer = ANSWER_W'(div_quot[INDEX_W-1:0]);
         end
      end else if (div_ovf || div_quot > QUOT_W'(UNIT_Q30)) begin
         fin_in.status = STATUS_ASIN;
      end else begin
         fin_in.asin_go = 1'b1;
      end
   end

   logic                      fin_vld_ff;
   fin_tag_type               fin_tag_ff;
   logic [MAG_W-1:0]          fin_mag_ff;
   logic                      fin_neg_ff;
   logic                      sq_vld_ff;
   fin_tag_type               sq_tag_ff;
   logic [RAD_W-1:0]          sq_ff;
   logic signed [SINE_W-1:0]  sq_p_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         fin_vld_ff <= 1'b0;
         sq_vld_ff  <= 1'b0;
      end else if (advance) begin
         fin_vld_ff <= div_valid;
         sq_vld_ff  <= fin_vld_ff;
      end
   end

   // Square of the argument for the cosine leg
   always_ff @(posedge clock) begin
      if (advance) begin
         fin_tag_ff <= fin_in;
         fin_mag_ff <= div_quot[MAG_W-1:0];
         fin_neg_ff <= div_tag.neg;
         sq_tag_ff  <= fin_tag_ff;
         sq_ff      <= RAD_W'(fin_mag_ff * fin_mag_ff);
         sq_p_ff    <= fin_neg_ff ? -SINE_W'(fin_mag_ff) : SINE_W'(fin_mag_ff);
      end
   end

   // ---------------- sqrt(1 - p*p), two radicand bits per stage ----------------
   logic                      rt_vld_ff [0:ROOT_W];
   fin_tag_type               rt_tag_ff [0:ROOT_W];
   logic [RAD_W-1:0]          rad_ff    [0:ROOT_W];
   logic [SQ_REM_W-1:0]       rrem_ff   [0:ROOT_W];
   logic [ROOT_W-1:0]         root_ff   [0:ROOT_W];
   logic signed [SINE_W-1:0]  rt_p_ff   [0:ROOT_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= ROOT_W; j++) rt_vld_ff[j] <= 1'b0;
      end else if (advance) begin
         rt_vld_ff[0] <= sq_vld_ff;
         for (int j = 1; j <= ROOT_W; j++) rt_vld_ff[j] <= rt_vld_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rt_tag_ff[0] <= sq_tag_ff;
         rad_ff[0]    <= RAD_ONE - sq_ff;
         rrem_ff[0]   <= '0;
         root_ff[0]   <= '0;
         rt_p_ff[0]   <= sq_p_ff;
      end
   end

   for (genvar i = 0; i < ROOT_W; i++) begin : g_root
      logic [SQ_REM_W+1:0] trial;
      logic [SQ_REM_W+1:0] test;
      logic                fits;

      assign trial = {rrem_ff[i], rad_ff[i][RAD_W-1 -: 2]};
      assign test  = (SQ_REM_W+2)'({root_ff[i], 2'b01});
      assign fits  = (trial >= test);

      always_ff @(posedge clock) begin
         if (advance) begin
            rt_tag_ff[i+1] <= rt_tag_ff[i];
            rt_p_ff[i+1]   <= rt_p_ff[i];
            rad_ff[i+1]    <= rad_ff[i] << 2;
            root_ff[i+1]   <= {root_ff[i][ROOT_W-2:0], fits};
            rrem_ff[i+1]   <= fits ? SQ_REM_W'(trial - test) : SQ_REM_W'(trial);
         end
      end
   end

   // ---------------- arcsine by CORDIC vectoring ----------------
   logic                        as_vld_ff [0:TRIG_ITERATIONS];
   fin_tag_type                 as_tag_ff [0:TRIG_ITERATIONS];
   logic signed [CORDIC_W-1:0]  ax_ff     [0:TRIG_ITERATIONS];
   logic signed [CORDIC_W-1:0]  ay_ff     [0:TRIG_ITERATIONS];
   logic signed [ZA_W-1:0]      az_ff     [0:TRIG_ITERATIONS];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= TRIG_ITERATIONS; j++) as_vld_ff[j] <= 1'b0;
      end else if (advance) begin
         as_vld_ff[0] <= rt_vld_ff[ROOT_W];
         for (int j = 1; j <= TRIG_ITERATIONS; j++) as_vld_ff[j] <= as_vld_ff[j-1];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         as_tag_ff[0] <= rt_tag_ff[ROOT_W];
         ax_ff[0]     <= CORDIC_W'(root_ff[ROOT_W]);
         ay_ff[0]     <= CORDIC_W'(rt_p_ff[ROOT_W]);
         az_ff[0]     <= '0;
      end
   end

   for (genvar k = 0; k < TRIG_ITERATIONS; k++) begin : g_asin
      localparam logic signed [ZA_W-1:0] ATAN_K = ZA_W'(atan_deg(k));
      logic signed [CORDIC_W-1:0] dx;
      logic signed [CORDIC_W-1:0] dy;

      assign dx = ay_ff[k] >>> k;
      assign dy = ax_ff[k] >>> k;

      always_ff @(posedge clock) begin
         if (advance) begin
            as_tag_ff[k+1] <= as_tag_ff[k];
            if (!ay_ff[k][CORDIC_W-1]) begin
               ax_ff[k+1] <= ax_ff[k] + dx;
               ay_ff[k+1] <= ay_ff[k] - dy;
               az_ff[k+1] <= az_ff[k] + ATAN_K;
            end else begin
               ax_ff[k+1] <= ax_ff[k] - dx;
               ay_ff[k+1] <= ay_ff[k] + dy;
               az_ff[k+1] <= az_ff[k] - ATAN_K;
            end
         end
      end
   end

   // ---------------- output register ----------------
   logic signed [ZA_W-1:0] angle_round;
   fin_tag_type            last_tag;

   assign last_tag    = as_tag_ff[TRIG_ITERATIONS];
   assign angle_round = (az_ff[TRIG_ITERATIONS] + ROUND_HALF) >>> SCALE_SH;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= as_vld_ff[TRIG_ITERATIONS];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         status_ff <= last_tag.status;
         answer_ff <= last_tag.asin_go ? ANSWER_W'(angle_round) : last_tag.answer;
      end
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.answer = $signed(answer_ff);
   assign rsp_ch.status = status_ff;

`ifndef SYNTHESIS
   a_flag_zero_answer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (status_ff == STATUS_ASIN || status_ff == STATUS_ZERO_DIV)
      |-> answer_ff == '0)
      else $error("flagged result carries a nonzero answer");

   a_sat_answer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff == STATUS_SAT
      |-> (answer_ff == '0 || answer_ff == ANSWER_W'(INDEX_MAX)))
      else $error("saturated index is neither zero nor full scale");

   a_rise_on_advance: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(advance))
      else $error("result appeared while the pipeline was frozen");

   a_asin_in_range: assert property (@(posedge clock) disable iff (reset)
      fin_vld_ff && fin_tag_ff.asin_go |-> fin_mag_ff <= UNIT_Q30)
      else $error("arcsine argument beyond one sent to the square root");
`endif

endmodule
